### rtl/sbi_pkg.sv
// shared widths, outcode constants and helper types for the segment / box test
`default_nettype none
package sbi_pkg;
  localparam int CW = 32;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam logic [5:0] CODE_Z_PAIR = 6'd48;
  localparam logic [5:0] CODE_Y_PAIR = 6'd12;
  localparam logic [5:0] CODE_X_PAIR = 6'd3;
  localparam logic [5:0] CODE_ALL    = 6'd63;
  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [DW:0]   ndiff_t;

  typedef struct packed {
    logic   valid;
    logic   decided;
    logic   result;
  } ctl_t;
endpackage
`default_nettype wire

### rtl/segment_box_intersect_core.sv
// top level: segment versus axis-aligned box intersection, one query per cycle
//
// channels: a query is taken when start is high and busy is low; busy is
// tied low, so a new query may enter every cycle. the answer appears on
// out_intersects for one cycle with out_valid high, once the query has passed
// through the pipeline (stage 1 outcodes and deltas, stage 2 plane range checks,
// stage 3 cross products, stage 4 compares, stage 5 face merge).
// throughput is one query per cycle, set by the fully pipelined multipliers.
// answers leave in query order; the receiver cannot stall, so nothing waits.
// reset clears only the valid bits of the pipeline; payload registers are
// left as they are. coordinates are signed q16.16; a point on a face counts
// as inside. an axis with zero segment delta has its faces skipped, and the
// opposite-corner outcode pattern answers true by rule.
`default_nettype none
module segment_box_intersect_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire sbi_pkg::coord_t in_box_min_x,
  input  wire sbi_pkg::coord_t in_box_min_y,
  input  wire sbi_pkg::coord_t in_box_min_z,
  input  wire sbi_pkg::coord_t in_box_max_x,
  input  wire sbi_pkg::coord_t in_box_max_y,
  input  wire sbi_pkg::coord_t in_box_max_z,
  input  wire sbi_pkg::coord_t in_start_x,
  input  wire sbi_pkg::coord_t in_start_y,
  input  wire sbi_pkg::coord_t in_start_z,
  input  wire sbi_pkg::coord_t in_end_x,
  input  wire sbi_pkg::coord_t in_end_y,
  input  wire sbi_pkg::coord_t in_end_z,
  output logic                out_valid,
  output logic                out_intersects
);
  import sbi_pkg::*;

  coord_t mn [3], mx [3], s [3], e [3];
  logic [5:0] c0, c1;
  ctl_t ctl_nxt;
  ctl_t c1_r, c2_r, c3_r, c4_r;
  diff_t dl_r [3], nmin_r [3], nmax_r [3], lo_r [3], hi_r [3];
  logic [5:0] fh;

  assign busy = 1'b0;
  assign mn[0] = in_box_min_x; assign mn[1] = in_box_min_y; assign mn[2] = in_box_min_z;
  assign mx[0] = in_box_max_x; assign mx[1] = in_box_max_y; assign mx[2] = in_box_max_z;
  assign s[0] = in_start_x; assign s[1] = in_start_y; assign s[2] = in_start_z;
  assign e[0] = in_end_x; assign e[1] = in_end_y; assign e[2] = in_end_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c0[2*a]   = s[a] < mn[a];
      c0[2*a+1] = !(s[a] < mn[a]) && (mx[a] < s[a]);
      c1[2*a]   = e[a] < mn[a];
      c1[2*a+1] = !(e[a] < mn[a]) && (mx[a] < e[a]);
    end
    ctl_nxt.valid = start;
    ctl_nxt.decided = 1'b1;
    ctl_nxt.result = 1'b0;
    if (c0 == '0 || c1 == '0) ctl_nxt.result = 1'b1;
    else if ((c0 & c1) != '0) ctl_nxt.result = 1'b0;
    else if ((c0 | c1) == CODE_Z_PAIR || (c0 | c1) == CODE_Y_PAIR
             || (c0 | c1) == CODE_X_PAIR) ctl_nxt.result = 1'b1;
    else if ((c0 ^ c1) == CODE_ALL) ctl_nxt.result = 1'b1;
    else ctl_nxt.decided = 1'b0;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      dl_r[a]   <= diff_t'(e[a]) - diff_t'(s[a]);
      nmin_r[a] <= diff_t'(mn[a]) - diff_t'(s[a]);
      nmax_r[a] <= diff_t'(mx[a]) - diff_t'(s[a]);
      lo_r[a]   <= diff_t'(mn[a]) - diff_t'(s[a]);
      hi_r[a]   <= diff_t'(mx[a]) - diff_t'(s[a]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_face
    localparam int AX = g / 2;
    localparam int BA = (AX + 1) % 3;
    localparam int BB = (AX + 2) % 3;
    sbi_face u_face (
      .clk  (clk),
      .d_in (dl_r[AX]),
      .n_in ((g % 2 == 0) ? nmin_r[AX] : nmax_r[AX]),
      .lo_a (lo_r[BA]), .hi_a (hi_r[BA]), .dl_a (dl_r[BA]),
      .lo_b (lo_r[BB]), .hi_b (hi_r[BB]), .dl_b (dl_r[BB]),
      .hit  (fh[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0; c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0; c4_r.valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c1_r.valid <= ctl_nxt.valid; c2_r.valid <= c1_r.valid;
      c3_r.valid <= c2_r.valid; c4_r.valid <= c3_r.valid;
      out_valid <= c4_r.valid;
    end
    c1_r.decided <= ctl_nxt.decided; c1_r.result <= ctl_nxt.result;
    c2_r.decided <= c1_r.decided;    c2_r.result <= c1_r.result;
    c3_r.decided <= c2_r.decided;    c3_r.result <= c2_r.result;
    c4_r.decided <= c3_r.decided;    c4_r.result <= c3_r.result;
    out_intersects <= c4_r.decided ? c4_r.result : (fh != '0);
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##5 out_valid) else $error("answer missing after query");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 5)) else $error("answer without query");
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule
`default_nettype wire

### rtl/sbi_face.sv
// one face-plane test: plane range check, then registered cross products, then a registered compare
`default_nettype none
module sbi_face (
  input  wire logic          clk,
  input  wire sbi_pkg::diff_t d_in,
  input  wire sbi_pkg::diff_t n_in,
  input  wire sbi_pkg::diff_t lo_a,
  input  wire sbi_pkg::diff_t hi_a,
  input  wire sbi_pkg::diff_t dl_a,
  input  wire sbi_pkg::diff_t lo_b,
  input  wire sbi_pkg::diff_t hi_b,
  input  wire sbi_pkg::diff_t dl_b,
  output logic               hit
);
  import sbi_pkg::*;

  ndiff_t d_nxt, n_nxt;
  logic   ok_nxt;
  ndiff_t d_r, n_r;
  diff_t  lo_a_r, hi_a_r, dl_a_r, lo_b_r, hi_b_r, dl_b_r;
  logic   ok_r;
  prod_t  pla_r, pha_r, ppa_r, plb_r, phb_r, ppb_r;
  logic   ok2_r;

  always_comb begin
    d_nxt = ndiff_t'(d_in);
    n_nxt = ndiff_t'(n_in);
    if (d_in < 0) begin
      d_nxt = -d_nxt;
      n_nxt = -n_nxt;
    end
    ok_nxt = (d_in != '0) && (n_nxt >= 0) && (n_nxt <= d_nxt);
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    n_r <= n_nxt;
    ok_r <= ok_nxt;
    lo_a_r <= lo_a; hi_a_r <= hi_a; dl_a_r <= dl_a;
    lo_b_r <= lo_b; hi_b_r <= hi_b; dl_b_r <= dl_b;
    pla_r <= prod_t'(lo_a_r) * prod_t'(d_r);
    pha_r <= prod_t'(hi_a_r) * prod_t'(d_r);
    ppa_r <= prod_t'(n_r) * prod_t'(dl_a_r);
    plb_r <= prod_t'(lo_b_r) * prod_t'(d_r);
    phb_r <= prod_t'(hi_b_r) * prod_t'(d_r);
    ppb_r <= prod_t'(n_r) * prod_t'(dl_b_r);
    ok2_r <= ok_r;
    hit <= ok2_r && (pla_r <= ppa_r) && (ppa_r <= pha_r)
                 && (plb_r <= ppb_r) && (ppb_r <= phb_r);
  end
endmodule
`default_nettype wire
